>>> hw/rtl/orls_pkg.sv
// shared types, constants and fixed-point helpers for the online rls model update
// no dependencies
package orls_pkg;

  localparam int unsigned DW = 64;
  localparam int unsigned N = 4;
  localparam logic signed [DW-1:0] GAIN2_RESET = 64'sd1166987806;
  localparam logic signed [DW-1:0] GAIN3_RESET = -64'sd747980150;
  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [5:0] IDX_COV = 6'd16;
  localparam logic [5:0] IDX_SMP = 6'd32;
  localparam logic [5:0] IDX_END = 6'd36;
  localparam logic [0:0] CMD_LOAD = 1'b0;
  localparam logic [0:0] CMD_UPDATE = 1'b1;
  localparam logic [0:0] REG_GAIN2 = 1'b0;
  localparam logic [0:0] REG_GAIN3 = 1'b1;

  typedef logic signed [DW-1:0] word_t;

  typedef struct packed {
    logic [0:0] cmd;
    logic [5:0] load_index;
    word_t      load_value;
    word_t      sample_0;
    word_t      sample_1;
    word_t      sample_2;
    word_t      sample_3;
    word_t      control_prev;
  } rls_item_t;

  typedef struct packed {
    logic [1:0] row_index;
    word_t      entry_col0;
    word_t      entry_col1;
    word_t      entry_col2;
    word_t      entry_col3;
    logic       last_row;
  } model_row_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VW,
    ST_S,
    ST_DIV,
    ST_Y,
    ST_GE,
    ST_UPD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

  function automatic word_t sat_add(word_t a, word_t b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? SMIN : SMAX;
    return s[DW-1:0];
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? SMIN : SMAX;
    return s[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] mag(word_t a);
    return a[DW-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic word_t finish(logic [DW-1:0] q, logic neg, logic ovf);
    if (neg) begin
      if (ovf || q[DW-1]) return SMIN;
      return ~q + 1'b1;
    end
    if (ovf || q[DW-1]) return SMAX;
    return q;
  endfunction

endpackage

>>> hw/rtl/orls_stream_if.sv
// valid/ready channel carrying one transaction payload
// depends on nothing
interface orls_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> hw/rtl/orls_mul.sv
// sequential fixed-point multiplier: four 32x32 partial products, round, saturate
// depends on orls_pkg
module orls_mul #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  orls_pkg::mul_req_t req,
  output logic             done,
  output orls_pkg::word_t  result
);
  import orls_pkg::*;

  logic [DW-1:0] ua, ub;
  logic          neg;
  logic [2*DW-1:0] acc;
  logic [2:0]    step;
  logic          busy;
  logic [31:0]   opa, opb;
  logic [63:0]   pp;
  logic [2*DW-1:0] rnd;
  logic [2*DW-1:0] sh;
  logic          ovf;

  always_comb begin
    unique case (step[1:0])
      2'd0: begin opa = ua[31:0];  opb = ub[31:0];  end
      2'd1: begin opa = ua[31:0];  opb = ub[63:32]; end
      2'd2: begin opa = ua[63:32]; opb = ub[31:0];  end
      default: begin opa = ua[63:32]; opb = ub[63:32]; end
    endcase
    pp = opa * opb;
    rnd = acc + ({{(2*DW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1));
    sh = rnd >> FRAC_BITS;
    ovf = |sh[2*DW-1:DW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        ua <= mag(req.a);
        ub <= mag(req.b);
        neg <= req.a[DW-1] ^ req.b[DW-1];
        acc <= '0;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (step == 3'd4) begin
          result <= finish(sh[DW-1:0], neg, ovf);
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          unique case (step[1:0])
            2'd0: acc <= acc + {64'd0, pp};
            2'd1, 2'd2: acc <= acc + ({64'd0, pp} << 32);
            default: acc <= acc + {pp, 64'd0};
          endcase
          step <= step + 3'd1;
        end
      end
    end
  end
endmodule

>>> hw/rtl/online_rls_model_update.sv
// online rls update of a 4x4 model: one shared sequential multiplier and a
// restoring divider step, sequenced by a small state machine
// each update item takes 94 multiplies and one divide; a load item is applied in idle
// one item at a time: a new item is taken only in idle; 4 result transactions per update
// reset: model, covariance and sample clear to zero, gains take plant defaults
module online_rls_model_update #(
  parameter int unsigned FRAC_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  orls_pkg::word_t      cfg_data,
  orls_stream_if.sink          in_ch,
  orls_stream_if.source        out_ch
);
  import orls_pkg::*;

  localparam int unsigned QB = 2 * FRAC_BITS + 1;

  word_t amat [16];
  word_t pmat [16];
  word_t psmp [4];
  word_t v [4];
  word_t w [4];
  word_t e [4];
  word_t ge [4];
  word_t gv [4];
  word_t xs [4];
  word_t gain2, gain3, u, s, gamma, acc0;

  state_t state, state_next;
  logic [1:0] i, j, ph;
  logic       wait_m;
  mul_req_t   mreq;
  logic       mdone;
  word_t      mres;

  logic [DW-1:0] dm, drem, dq;
  logic [6:0]    dcnt;
  logic          dovf, dneg;
  logic [DW:0]   rem2;
  word_t         dsum;

  orls_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .req(mreq), .done(mdone), .result(mres)
  );

  assign in_ch.ready = (state == ST_IDLE);
  assign dsum = sat_add(word_t'(64'd1 << FRAC_BITS), s);
  assign rem2 = {drem, (dcnt == 7'(QB))};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_ch.valid && in_ch.data.cmd != CMD_LOAD) state_next = ST_VW;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain2 <= GAIN2_RESET;
      gain3 <= GAIN3_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_GAIN2) gain2 <= cfg_data;
      else gain3 <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mreq.start <= 1'b0;
      wait_m <= 1'b0;
      out_ch.valid <= 1'b0;
      for (int k = 0; k < 16; k++) begin amat[k] <= '0; pmat[k] <= '0; end
      for (int k = 0; k < 4; k++) psmp[k] <= '0;
      i <= '0; j <= '0; ph <= '0;
    end else begin
      mreq.start <= 1'b0;
      unique case (state)
        ST_IDLE: if (in_ch.valid) begin
          if (in_ch.data.cmd == CMD_LOAD) begin
            if (in_ch.data.load_index < IDX_COV) amat[in_ch.data.load_index[3:0]] <=
                in_ch.data.load_value;
            else if (in_ch.data.load_index < IDX_SMP) pmat[in_ch.data.load_index[3:0]] <=
                in_ch.data.load_value;
            else if (in_ch.data.load_index < IDX_END) psmp[in_ch.data.load_index[1:0]] <=
                in_ch.data.load_value;
          end else begin
            xs[0] <= in_ch.data.sample_0;
            xs[1] <= in_ch.data.sample_1;
            xs[2] <= in_ch.data.sample_2;
            xs[3] <= in_ch.data.sample_3;
            u <= in_ch.data.control_prev;
            i <= '0; j <= '0; ph <= '0;
            acc0 <= '0; s <= '0;
            wait_m <= 1'b0;
            state <= state_next;
          end
        end
        // ph 0: P[i][j]*p[j], 1: p[j]*P[j][i], 2: A[i][j]*p[j]
        ST_VW: begin
          if (!wait_m) begin
            mreq.start <= 1'b1;
            unique case (ph)
              2'd0: begin mreq.a <= pmat[{i, j}]; mreq.b <= psmp[j]; end
              2'd1: begin mreq.a <= psmp[j]; mreq.b <= pmat[{j, i}]; end
              default: begin mreq.a <= amat[{i, j}]; mreq.b <= psmp[j]; end
            endcase
            wait_m <= 1'b1;
          end else if (mdone) begin
            wait_m <= 1'b0;
            if (j == 2'd3) begin
              unique case (ph)
                2'd0: v[i] <= sat_add(acc0, mres);
                2'd1: w[i] <= sat_add(acc0, mres);
                default: e[i] <= sat_add(acc0, mres);
              endcase
              acc0 <= '0;
              j <= '0;
              if (ph == 2'd2) begin
                ph <= '0;
                if (i == 2'd3) begin i <= '0; state <= ST_S; end
                else i <= i + 2'd1;
              end else ph <= ph + 2'd1;
            end else begin
              acc0 <= sat_add(acc0, mres);
              j <= j + 2'd1;
            end
          end
        end
        ST_S: begin
          if (!wait_m) begin
            mreq.start <= 1'b1;
            mreq.a <= psmp[i]; mreq.b <= v[i];
            wait_m <= 1'b1;
          end else if (mdone) begin
            wait_m <= 1'b0;
            s <= sat_add(s, mres);
            if (i == 2'd3) begin
              i <= '0;
              state <= ST_DIV;
              dcnt <= '0;
            end else i <= i + 2'd1;
          end
        end
        ST_DIV: begin
          if (dcnt == '0 && !wait_m) begin
            dm <= mag(dsum);
            dneg <= dsum[DW-1];
            drem <= '0; dq <= '0; dovf <= 1'b0;
            dcnt <= 7'(QB);
            wait_m <= 1'b1;
          end else if (dcnt != '0) begin
            if (dm == '0) begin
              gamma <= SMAX; dcnt <= '0; wait_m <= 1'b0; state <= ST_Y;
            end else begin
              if (rem2 >= {1'b0, dm}) begin
                drem <= DW'(rem2 - {1'b0, dm});
                if (dcnt - 7'd1 >= 7'd63) dovf <= 1'b1;
                else dq[6'(dcnt - 7'd1)] <= 1'b1;
              end else drem <= rem2[DW-1:0];
              dcnt <= dcnt - 7'd1;
            end
          end else begin
            gamma <= finish(dq + DW'(drem >= dm - drem), dneg, dovf);
            wait_m <= 1'b0;
            state <= ST_Y;
          end
        end
        ST_Y: begin
          if (!wait_m) begin
            mreq.start <= 1'b1;
            mreq.a <= ph[0] ? gain3 : gain2; mreq.b <= u;
            wait_m <= 1'b1;
          end else if (mdone) begin
            wait_m <= 1'b0;
            if (ph[0]) begin
              xs[3] <= xs[3];
              e[3] <= sat_sub(sat_sub(xs[3], mres), e[3]);
              e[0] <= sat_sub(xs[0], e[0]);
              e[1] <= sat_sub(xs[1], e[1]);
              ph <= '0;
              state <= ST_GE;
            end else begin
              e[2] <= sat_sub(sat_sub(xs[2], mres), e[2]);
              ph <= 2'd1;
            end
          end
        end
        ST_GE: begin
          if (!wait_m) begin
            mreq.start <= 1'b1;
            mreq.a <= gamma; mreq.b <= ph[0] ? v[i] : e[i];
            wait_m <= 1'b1;
          end else if (mdone) begin
            wait_m <= 1'b0;
            if (ph[0]) gv[i] <= mres; else ge[i] <= mres;
            if (ph[0]) begin
              ph <= '0;
              if (i == 2'd3) begin i <= '0; state <= ST_UPD; end
              else i <= i + 2'd1;
            end else ph <= 2'd1;
          end
        end
        ST_UPD: begin
          if (!wait_m) begin
            mreq.start <= 1'b1;
            mreq.a <= ph[0] ? gv[i] : ge[i]; mreq.b <= w[j];
            wait_m <= 1'b1;
          end else if (mdone) begin
            wait_m <= 1'b0;
            if (ph[0]) pmat[{i, j}] <= sat_sub(pmat[{i, j}], mres);
            else amat[{i, j}] <= sat_add(amat[{i, j}], mres);
            if (ph[0]) begin
              ph <= '0;
              j <= j + 2'd1;
              if (j == 2'd3) begin
                i <= i + 2'd1;
                if (i == 2'd3) begin
                  for (int k = 0; k < 4; k++) psmp[k] <= xs[k];
                  i <= '0;
                  state <= ST_OUT;
                end
              end
            end else ph <= 2'd1;
          end
        end
        ST_OUT: begin
          if (!out_ch.valid) begin
            out_ch.valid <= 1'b1;
            out_ch.data.row_index <= i;
            out_ch.data.entry_col0 <= amat[{i, 2'd0}];
            out_ch.data.entry_col1 <= amat[{i, 2'd1}];
            out_ch.data.entry_col2 <= amat[{i, 2'd2}];
            out_ch.data.entry_col3 <= amat[{i, 2'd3}];
            out_ch.data.last_row <= (i == 2'd3);
          end else if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            i <= i + 2'd1;
            if (i == 2'd3) begin i <= '0; state <= ST_IDLE; end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

>>> verif/tb_online_rls_model_update.sv
// self-checking testbench for online_rls_model_update: directed table, then random
// load/update traffic under four gain settings, checked against a bit-true predictor
// depends on orls_pkg, orls_stream_if and the rtl top level
`timescale 1ns / 1ps

module tb_online_rls_model_update;
  import orls_pkg::*;

  localparam int unsigned FB = 32;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam word_t ONE = 64'sd1 <<< FB;

  typedef struct {
    rls_item_t item;
    bit        zero_rows;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_GAIN2;
  word_t cfg_data = '0;

  orls_stream_if #(.T(rls_item_t)) in_ch ();
  orls_stream_if #(.T(model_row_t)) out_ch ();

  online_rls_model_update #(.FRAC_BITS(FB)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  word_t gain2, gain3;
  word_t model_m[16];
  word_t cov_m[16];
  word_t prev_x[4];
  model_row_t model_row_q[$];

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned n_loads = 0, n_updates = 0, n_rows = 0, n_zero_den = 0;
  int unsigned burst_left = 0;
  int unsigned ready_mode = 0;
  dir_row_t dir_tbl[$];

  function automatic word_t clamp(logic [63:0] q, logic neg, logic ovf);
    if (neg) begin
      if (ovf || q[63]) return SMIN;
      return -q;
    end
    if (ovf || q[63]) return SMAX;
    return q;
  endfunction

  function automatic word_t s_add(word_t a, word_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(SMAX)) return SMAX;
    if (s < 65'(SMIN)) return SMIN;
    return s[63:0];
  endfunction

  function automatic word_t s_sub(word_t a, word_t b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(SMAX)) return SMAX;
    if (s < 65'(SMIN)) return SMIN;
    return s[63:0];
  endfunction

  function automatic logic [63:0] abs_of(word_t a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  function automatic word_t qmul(word_t a, word_t b);
    logic [127:0] p;
    p = {64'd0, abs_of(a)} * {64'd0, abs_of(b)};
    p = p + (128'd1 << (FB - 1));
    return clamp(p[FB +: 64], a[63] ^ b[63], |(p >> (64 + FB)));
  endfunction

  function automatic word_t qrecip(word_t d);
    logic [128:0] num, qf, r;
    logic [63:0] m, q;
    m = abs_of(d);
    if (m == 0) return SMAX;
    num = 129'd1 << (2 * FB);
    qf = num / m;
    r = num % m;
    q = {1'b0, qf[62:0]};
    if ((r << 1) >= {65'd0, m}) q = q + 64'd1;
    return clamp(q, d[63], |(qf >> 63));
  endfunction

  // applies one accepted transaction to the predicted state and, for an update, queues the model rows
  task automatic rls_apply(input rls_item_t it, input bit zero_rows);
    word_t x[4], v[4], w[4], e[4], y[4];
    word_t s, gamma, ge, gv;
    model_row_t r;
    if (it.cmd == CMD_LOAD) begin
      n_loads++;
      if (it.load_index < IDX_COV) model_m[it.load_index[3:0]] = it.load_value;
      else if (it.load_index < IDX_SMP) cov_m[it.load_index[3:0]] = it.load_value;
      else if (it.load_index < IDX_END) prev_x[it.load_index[1:0]] = it.load_value;
      return;
    end
    n_updates++;
    x[0] = it.sample_0; x[1] = it.sample_1; x[2] = it.sample_2; x[3] = it.sample_3;
    for (int i = 0; i < 4; i++) begin
      v[i] = '0; w[i] = '0; e[i] = '0;
      for (int j = 0; j < 4; j++) begin
        v[i] = s_add(v[i], qmul(cov_m[i*4+j], prev_x[j]));
        w[i] = s_add(w[i], qmul(prev_x[j], cov_m[j*4+i]));
        e[i] = s_add(e[i], qmul(model_m[i*4+j], prev_x[j]));
      end
    end
    s = '0;
    for (int i = 0; i < 4; i++) s = s_add(s, qmul(prev_x[i], v[i]));
    if (s_add(ONE, s) == 0) n_zero_den++;
    gamma = qrecip(s_add(ONE, s));
    y[0] = x[0];
    y[1] = x[1];
    y[2] = s_sub(x[2], qmul(gain2, it.control_prev));
    y[3] = s_sub(x[3], qmul(gain3, it.control_prev));
    for (int i = 0; i < 4; i++) e[i] = s_sub(y[i], e[i]);
    for (int i = 0; i < 4; i++) begin
      ge = qmul(gamma, e[i]);
      gv = qmul(gamma, v[i]);
      for (int j = 0; j < 4; j++) begin
        model_m[i*4+j] = s_add(model_m[i*4+j], qmul(ge, w[j]));
        cov_m[i*4+j] = s_sub(cov_m[i*4+j], qmul(gv, w[j]));
      end
    end
    for (int i = 0; i < 4; i++) prev_x[i] = x[i];
    for (int i = 0; i < 4; i++) begin
      r.row_index = 2'(i);
      r.entry_col0 = zero_rows ? '0 : model_m[i*4+0];
      r.entry_col1 = zero_rows ? '0 : model_m[i*4+1];
      r.entry_col2 = zero_rows ? '0 : model_m[i*4+2];
      r.entry_col3 = zero_rows ? '0 : model_m[i*4+3];
      r.last_row = (i == 3);
      model_row_q.push_back(r);
    end
  endtask

  function automatic word_t rnd_val();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return SMAX;
      2: return SMIN;
      3: return '0;
      default: return {{32{r[31]}}, r} <<< $urandom_range(0, 3);
    endcase
  endfunction

  function automatic rls_item_t rnd_item();
    rls_item_t it;
    it.cmd = ($urandom_range(0, 9) < 6) ? CMD_UPDATE : CMD_LOAD;
    it.load_index = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 35));
    it.load_value = rnd_val();
    it.sample_0 = rnd_val();
    it.sample_1 = rnd_val();
    it.sample_2 = rnd_val();
    it.sample_3 = rnd_val();
    it.control_prev = rnd_val();
    return it;
  endfunction

  function automatic rls_item_t mk_load(logic [5:0] idx, word_t val);
    rls_item_t it;
    it = rnd_item();
    it.cmd = CMD_LOAD;
    it.load_index = idx;
    it.load_value = val;
    return it;
  endfunction

  function automatic rls_item_t mk_upd(word_t a, word_t b, word_t c, word_t d, word_t u);
    rls_item_t it;
    it = rnd_item();
    it.cmd = CMD_UPDATE;
    it.sample_0 = a; it.sample_1 = b; it.sample_2 = c; it.sample_3 = d;
    it.control_prev = u;
    return it;
  endfunction

  task automatic send(input rls_item_t it, input bit zero_rows);
    if (burst_left == 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 20)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.data = it;
    do @(posedge clk); while (!in_ch.ready);
    rls_apply(it, zero_rows);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    burst_left = 0;
    while (model_row_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_gain(input logic [0:0] idx, input word_t val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_GAIN2) gain2 = val;
    else gain3 = val;
  endtask

  // receiver stall pattern and result checking
  always @(negedge clk) begin
    if (cycles % 64 == 0) ready_mode = $urandom_range(0, 2);
    case (ready_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    model_row_t exp_r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_rows++;
      if (model_row_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected row transaction %p", out_ch.data);
      end else begin
        exp_r = model_row_q.pop_front();
        if (out_ch.data !== exp_r) begin
          errors++;
          if (errors <= 10)
            $display("row mismatch at cycle %0d\n  exp %p\n  got %p", cycles, exp_r, out_ch.data);
        end
      end
    end
  end

  initial begin
    word_t gset2[4], gset3[4];
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    gain2 = GAIN2_RESET;
    gain3 = GAIN3_RESET;
    for (int i = 0; i < 16; i++) begin
      model_m[i] = '0;
      cov_m[i] = '0;
    end
    for (int i = 0; i < 4; i++) prev_x[i] = '0;

    // zero state after reset leaves the model zero
    dir_tbl.push_back('{mk_upd(ONE, -ONE, SMAX, SMIN, ONE), 1'b1});
    dir_tbl.push_back('{mk_upd('0, '0, '0, '0, '0), 1'b1});
    for (int i = 0; i < 4; i++) dir_tbl.push_back('{mk_load(6'(16 + 5*i), ONE), 1'b0});
    dir_tbl.push_back('{mk_load(6'd0, SMAX), 1'b0});
    dir_tbl.push_back('{mk_load(6'd15, SMIN), 1'b0});
    dir_tbl.push_back('{mk_load(6'd36, SMAX), 1'b0});
    dir_tbl.push_back('{mk_load(6'd63, SMIN), 1'b0});
    dir_tbl.push_back('{mk_upd(ONE, 2*ONE, -ONE, ONE >>> 1, ONE), 1'b0});
    dir_tbl.push_back('{mk_upd(SMAX, SMIN, SMAX, SMIN, SMAX), 1'b0});
    dir_tbl.push_back('{mk_upd(ONE, '0, ONE, '0, SMIN), 1'b0});
    // zero denominator: P00 = -1, p = e0
    for (int i = 16; i < 32; i++) dir_tbl.push_back('{mk_load(6'(i), '0), 1'b0});
    dir_tbl.push_back('{mk_load(6'd16, -ONE), 1'b0});
    dir_tbl.push_back('{mk_load(6'd32, ONE), 1'b0});
    for (int i = 33; i < 36; i++) dir_tbl.push_back('{mk_load(6'(i), '0), 1'b0});
    dir_tbl.push_back('{mk_upd(ONE, ONE, ONE, ONE, ONE), 1'b0});

    gset2[0] = GAIN2_RESET; gset3[0] = GAIN3_RESET;
    gset2[1] = SMAX;        gset3[1] = SMIN;
    gset2[2] = '0;          gset3[2] = '0;
    gset2[3] = rnd_val();   gset3[3] = {$urandom, $urandom};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tbl[k]) send(dir_tbl[k].item, dir_tbl[k].zero_rows);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_gain(REG_GAIN2, gset2[ph]);
      write_gain(REG_GAIN3, gset3[ph]);
      // restart from a well-conditioned covariance in half the phases
      if (ph % 2 == 0)
        for (int i = 0; i < 16; i++) send(mk_load(6'(16 + i), (i % 5 == 0) ? ONE : '0), 1'b0);
      for (int k = 0; k < 85; k++) send(rnd_item(), 1'b0);
      drain();
    end

    $display("covered %0d updates, %0d loads, %0d row transactions, %0d zero denominators",
             n_updates, n_loads, n_rows, n_zero_den);
    $display("four gain settings including both extremes, random sender gaps and sink stalls");
    if (errors == 0 && model_row_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d rows outstanding", errors, model_row_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
